// File: hw/rtl/mouse_button_press_classifier_assert.svh
// ----------------------------------------------------------------------------
// Mouse button press classifier assertion macros
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MOUSE_BUTTON_PRESS_CLASSIFIER_ASSERT_SVH
`define MOUSE_BUTTON_PRESS_CLASSIFIER_ASSERT_SVH

`ifndef SYNTH

// property must hold at every edge
`define MBPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true
`define MBPC_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`else

`define MBPC_ASSERT(lbl, prop, msg)
`define MBPC_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

// File: hw/rtl/mbpc_pkg.sv
// ----------------------------------------------------------------------------
// mbpc_pkg
// Shared types and codes of the mouse button press classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package mbpc_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned RADIUS_W = 15;
  localparam int unsigned SEL_W    = 3;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_FRAME = 2'd0,
    CMD_MOVE  = 2'd1,
    CMD_LEVEL = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    BST_RELEASED = 2'd0,
    BST_PRESSED  = 2'd1,
    BST_HELD     = 2'd2,
    BST_REPEAT   = 2'd3
  } btn_state_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOLD_MIN  = 2'd0,
    CFG_DC_WINDOW = 2'd1,
    CFG_DC_RADIUS = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [TIME_W-1:0]        now_time;
    logic                     focused;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [SEL_W-1:0]         button_select;
    logic                     button_down;
  } in_item_t;

  typedef struct packed {
    logic [SEL_W-1:0]  button_number;
    logic [1:0]        button_state;
    logic [TIME_W-1:0] hold_time;
    logic              last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic rd;
    logic sq;
    logic ev;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/mbpc_ctrl.sv
// ----------------------------------------------------------------------------
// mbpc_ctrl
// Sequencer that walks the buttons on a focused frame beat, three steps each.
// ----------------------------------------------------------------------------
`default_nettype none

module mbpc_ctrl #(
  parameter int unsigned NUM_BUTTONS = 8,
  parameter int unsigned IDX_W       = 3
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  input  wire mbpc_pkg::in_item_t  in_item_i,
  output logic                     in_ready_o,
  input  wire mbpc_pkg::dp_status_t status_i,
  output mbpc_pkg::ctrl_cmd_t      cmd_o,
  output logic [IDX_W-1:0]         idx_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_SQ,
    S_EV
  } state_e;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              start;
  logic              ev_fire;
  logic              last_btn;

  assign start    = in_valid_i && (state_q == S_IDLE) &&
                    (in_item_i.command == mbpc_pkg::CMD_FRAME) && in_item_i.focused;
  assign ev_fire  = (state_q == S_EV) && !status_i.out_busy;
  assign last_btn = (idx_q == IDX_W'(NUM_BUTTONS - 1));

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_RD;
          idx_d   = '0;
        end
      end
      S_RD: state_d = S_SQ;
      S_SQ: state_d = S_EV;
      S_EV: begin
        if (ev_fire) begin
          if (last_btn) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_RD;
            idx_d   = idx_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o.rd   = (state_q == S_RD);
  assign cmd_o.sq   = (state_q == S_SQ);
  assign cmd_o.ev   = ev_fire;
  assign idx_o      = idx_q;

endmodule

`default_nettype wire

// File: hw/rtl/mbpc_datapath.sv
// ----------------------------------------------------------------------------
// mbpc_datapath
// Pointer, levels, per-button press records, distance squares and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mbpc_datapath #(
  parameter int unsigned NUM_BUTTONS = 8,
  parameter int unsigned IDX_W       = 3
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire [mbpc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire [mbpc_pkg::TIME_W-1:0]         cfg_data_i,
  input  wire                                in_accept_i,
  input  wire mbpc_pkg::in_item_t            in_item_i,
  input  wire mbpc_pkg::ctrl_cmd_t           cmd_i,
  input  wire [IDX_W-1:0]                    idx_i,
  output mbpc_pkg::dp_status_t               status_o,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output mbpc_pkg::out_item_t                out_item_o
);

  localparam int unsigned TW = mbpc_pkg::TIME_W;
  localparam int unsigned PW = mbpc_pkg::POS_W;
  localparam int unsigned RW = mbpc_pkg::RADIUS_W;

  // configuration
  logic [TW-1:0]     hold_min_q, win_q;
  logic [RW-1:0]     radius_q;
  logic [2*RW-1:0]   r2_q;

  // shared state
  logic signed [PW-1:0]    ptr_x_q, ptr_y_q;
  logic [NUM_BUTTONS-1:0]  levels_q;
  logic [TW-1:0]           now_q;

  // per-button records
  mbpc_pkg::btn_state_e   pst_q    [NUM_BUTTONS];
  logic [TW-1:0]          click_t_q[NUM_BUTTONS];
  logic [TW-1:0]          prev_t_q [NUM_BUTTONS];
  logic signed [PW-1:0]   cx_q     [NUM_BUTTONS];
  logic signed [PW-1:0]   cy_q     [NUM_BUTTONS];
  logic [TW-1:0]          hold_q   [NUM_BUTTONS];

  // stage registers
  logic                   lvl_q, hold_ge_q, win_lt_q;
  mbpc_pkg::btn_state_e   st_q;
  logic [TW-1:0]          elapsed_q;
  logic signed [PW:0]     dx_q, dy_q;
  logic [TW-1:0]          sqx_q, sqy_q;

  // result register
  logic                   out_valid_q;
  mbpc_pkg::out_item_t    out_q;

  logic [TW-1:0]          elapsed_d;
  logic signed [PW:0]     dx_d, dy_d;
  logic signed [2*PW+1:0] px, py;
  logic [TW:0]            d2;
  logic                   near;
  mbpc_pkg::btn_state_e   st_n;
  logic                   sel_ok;

  assign elapsed_d = now_q - click_t_q[idx_i];
  assign dx_d = {ptr_x_q[PW-1], ptr_x_q} - {cx_q[idx_i][PW-1], cx_q[idx_i]};
  assign dy_d = {ptr_y_q[PW-1], ptr_y_q} - {cy_q[idx_i][PW-1], cy_q[idx_i]};
  assign px   = dx_q * dx_q;
  assign py   = dy_q * dy_q;
  assign d2   = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign near = d2 < {{(TW + 1 - 2*RW){1'b0}}, r2_q};
  assign sel_ok = ({1'b0, in_item_i.button_select} < 4'(NUM_BUTTONS));

  always_comb begin
    st_n = st_q;
    if (!lvl_q) begin
      st_n = mbpc_pkg::BST_RELEASED;
    end else begin
      if (st_q == mbpc_pkg::BST_PRESSED) begin
        if (hold_ge_q) st_n = mbpc_pkg::BST_HELD;
        if (win_lt_q && near) st_n = mbpc_pkg::BST_REPEAT;
      end
      if (st_n == mbpc_pkg::BST_RELEASED) st_n = mbpc_pkg::BST_PRESSED;
    end
  end

  // configuration and shared state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_min_q <= TW'(500);
      win_q      <= TW'(300);
      radius_q   <= RW'(4);
      r2_q       <= (2*RW)'(16);
      ptr_x_q    <= '0;
      ptr_y_q    <= '0;
      levels_q   <= '0;
      now_q      <= '0;
    end else begin
      r2_q <= (2*RW)'(radius_q * radius_q);
      if (cfg_we_i) begin
        case (cfg_index_i)
          mbpc_pkg::CFG_HOLD_MIN:  hold_min_q <= cfg_data_i;
          mbpc_pkg::CFG_DC_WINDOW: win_q      <= cfg_data_i;
          mbpc_pkg::CFG_DC_RADIUS: radius_q   <= cfg_data_i[RW-1:0];
          default: ;
        endcase
      end
      if (in_accept_i) begin
        case (in_item_i.command)
          mbpc_pkg::CMD_FRAME: now_q <= in_item_i.now_time;
          mbpc_pkg::CMD_MOVE: begin
            ptr_x_q <= in_item_i.pos_x;
            ptr_y_q <= in_item_i.pos_y;
          end
          mbpc_pkg::CMD_LEVEL: begin
            if (sel_ok) levels_q[in_item_i.button_select[IDX_W-1:0]] <= in_item_i.button_down;
          end
          default: ;
        endcase
      end
    end
  end

  // per-button records, written back on the evaluate step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        pst_q[i]     <= mbpc_pkg::BST_RELEASED;
        click_t_q[i] <= '0;
        prev_t_q[i]  <= '0;
        cx_q[i]      <= '0;
        cy_q[i]      <= '0;
        hold_q[i]    <= '0;
      end
    end else if (cmd_i.ev) begin
      pst_q[idx_i] <= st_n;
      if (!lvl_q) begin
        cx_q[idx_i] <= '0;
        cy_q[idx_i] <= '0;
      end else begin
        if (st_n == mbpc_pkg::BST_HELD) hold_q[idx_i] <= elapsed_q;
        if (st_q == mbpc_pkg::BST_RELEASED) begin
          cx_q[idx_i]      <= ptr_x_q;
          cy_q[idx_i]      <= ptr_y_q;
          prev_t_q[idx_i]  <= click_t_q[idx_i];
          click_t_q[idx_i] <= now_q;
        end
      end
    end
  end

  // read and square steps
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      lvl_q     <= levels_q[idx_i];
      st_q      <= pst_q[idx_i];
      elapsed_q <= elapsed_d;
      hold_ge_q <= (elapsed_d >= hold_min_q);
      win_lt_q  <= ((click_t_q[idx_i] - prev_t_q[idx_i]) < win_q);
      dx_q      <= dx_d;
      dy_q      <= dy_d;
    end
    if (cmd_i.sq) begin
      sqx_q <= px[TW-1:0];
      sqy_q <= py[TW-1:0];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.ev) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ev) begin
      out_q.button_number <= mbpc_pkg::SEL_W'(idx_i);
      out_q.button_state  <= st_n;
      out_q.hold_time     <= (lvl_q && st_n == mbpc_pkg::BST_HELD) ? elapsed_q : hold_q[idx_i];
      out_q.last          <= (idx_i == IDX_W'(NUM_BUTTONS - 1));
    end
  end

  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/mouse_button_press_classifier.sv
// ----------------------------------------------------------------------------
// mouse_button_press_classifier
// Tracks pointer and button levels and reports per-button press state on
// focused frame beats.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries commands (tuser): pointer move, button level change or
//   frame tick. Move and level beats update state in the cycle they are
//   taken and produce nothing. A frame beat with focused set walks all
//   NUM_BUTTONS buttons and emits one m_axis beat per button, button 0
//   first, tlast on the final one. Unfocused frames and unknown commands
//   are dropped.
//   Each button goes through record read, distance squares, and evaluate
//   and write back, in that order. s_axis_tready is low during the walk
//   and high otherwise, also while a result waits in the output register.
//   When m_axis stalls the walk holds at the evaluate step of the next
//   button until the output register drains.
//   The cfg channel is always ready; write only while the block is idle.
//   Reset clears pointer, levels and all button records and loads the
//   default hold time, double-click window and radius.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mouse_button_press_classifier_assert.svh"

module mouse_button_press_classifier #(
  parameter int unsigned NUM_BUTTONS = 8
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // cfg: index 0 hold_min_time, 1 double_click_window, 2 double_click_radius
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire [mbpc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire [mbpc_pkg::TIME_W-1:0]           cfg_data_i,
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: now_time[31:0], focused[32], pos_x[48:33], pos_y[64:49],
  //        button_select[67:65], button_down[68], zero[71:69]
  input  wire [mbpc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // tuser: command[1:0]
  input  wire [mbpc_pkg::CMD_W-1:0]            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // tdata: button_number[2:0], button_state[4:3], hold_time[36:5], zero[39:37]
  output logic [mbpc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                 m_axis_tlast
);

  localparam int unsigned IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  mbpc_pkg::in_item_t   in_item;
  mbpc_pkg::out_item_t  out_item;
  mbpc_pkg::ctrl_cmd_t  cmd;
  mbpc_pkg::dp_status_t status;
  logic [IDX_W-1:0]     idx;
  logic                 in_accept;

  assign in_item.command       = s_axis_tuser;
  assign in_item.now_time      = s_axis_tdata[31:0];
  assign in_item.focused       = s_axis_tdata[32];
  assign in_item.pos_x         = s_axis_tdata[48:33];
  assign in_item.pos_y         = s_axis_tdata[64:49];
  assign in_item.button_select = s_axis_tdata[67:65];
  assign in_item.button_down   = s_axis_tdata[68];

  assign in_accept   = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  mbpc_ctrl #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_item_i  (in_item),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd),
    .idx_o      (idx)
  );

  mbpc_datapath #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .IDX_W       (IDX_W)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_accept_i (in_accept),
    .in_item_i   (in_item),
    .cmd_i       (cmd),
    .idx_i       (idx),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (out_item)
  );

  assign m_axis_tdata = {3'b000, out_item.hold_time, out_item.button_state,
                         out_item.button_number};
  assign m_axis_tlast = out_item.last;

  `MBPC_ASSERT(a_frame_blocks_input,
    in_accept && (s_axis_tuser == mbpc_pkg::CMD_FRAME) && s_axis_tdata[32] |=> !s_axis_tready,
    "focused frame beat did not start the button walk")
  `MBPC_ASSERT(a_read_then_square, cmd.rd |=> cmd.sq,
    "record read not followed by square step")
  `MBPC_ASSERT(a_eval_fills_output, cmd.ev |=> m_axis_tvalid,
    "evaluate step did not load the output register")
  `MBPC_ASSERT_NEVER(a_busy_while_ready, s_axis_tready && (cmd.rd || cmd.sq),
    "input ready during button walk")

endmodule

`default_nettype wire

// File: bench/mbpc_checker.sv
// ----------------------------------------------------------------------------
// mbpc_checker
// Watches the cfg, input and result channels of the mouse button press
// classifier. It keeps its own copy of the registers, pointer, levels and
// per-button press records and works out the result beats of every accepted
// focused frame beat. Each result beat is compared field by field with the
// oldest expected one. It hands the mismatch count and the number of
// outstanding beats to the bench top.
// ----------------------------------------------------------------------------
module mbpc_checker #(
  parameter int unsigned NUM_BUTTONS = 8
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_valid_i,
  input  wire                                 cfg_ready_o,
  input  wire [mbpc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire [mbpc_pkg::TIME_W-1:0]          cfg_data_i,
  input  wire                                 s_axis_tvalid,
  input  wire                                 s_axis_tready,
  // tdata: now_time, focused, pos_x, pos_y, button_select, button_down
  input  wire [mbpc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // tuser: command
  input  wire [mbpc_pkg::CMD_W-1:0]           s_axis_tuser,
  input  wire                                 m_axis_tvalid,
  input  wire                                 m_axis_tready,
  // tdata: button_number, button_state, hold_time
  input  wire [mbpc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  wire                                 m_axis_tlast,
  output int unsigned                         fail_count_o,
  output int unsigned                         pending_o
);

  localparam int unsigned TIME_W    = mbpc_pkg::TIME_W;
  localparam int unsigned POS_W     = mbpc_pkg::POS_W;
  localparam int unsigned SEL_W     = mbpc_pkg::SEL_W;
  localparam int unsigned RADIUS_W  = mbpc_pkg::RADIUS_W;
  localparam int unsigned FOCUS_BIT = TIME_W;
  localparam int unsigned X_LSB     = FOCUS_BIT + 1;
  localparam int unsigned Y_LSB     = X_LSB + POS_W;
  localparam int unsigned SEL_LSB   = Y_LSB + POS_W;
  localparam int unsigned DOWN_BIT  = SEL_LSB + SEL_W;
  localparam int unsigned REPORT_MAX = 10;

  logic [TIME_W-1:0]       hold_min_q;
  logic [TIME_W-1:0]       dc_window_q;
  logic [RADIUS_W-1:0]     dc_radius_q;
  logic signed [POS_W-1:0] ptr_x_q;
  logic signed [POS_W-1:0] ptr_y_q;
  logic [NUM_BUTTONS-1:0]  levels_q;
  mbpc_pkg::btn_state_e    press_q        [NUM_BUTTONS];
  logic [TIME_W-1:0]       click_t_q      [NUM_BUTTONS];
  logic [TIME_W-1:0]       prev_click_t_q [NUM_BUTTONS];
  logic [TIME_W-1:0]       hold_q         [NUM_BUTTONS];
  logic signed [POS_W-1:0] click_x_q      [NUM_BUTTONS];
  logic signed [POS_W-1:0] click_y_q      [NUM_BUTTONS];
  mbpc_pkg::out_item_t     expected_beats [$];

  task automatic clear_model();
    hold_min_q  = 32'd500;
    dc_window_q = 32'd300;
    dc_radius_q = 15'd4;
    ptr_x_q     = '0;
    ptr_y_q     = '0;
    levels_q    = '0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      press_q[b]        = mbpc_pkg::BST_RELEASED;
      click_t_q[b]      = '0;
      prev_click_t_q[b] = '0;
      hold_q[b]         = '0;
      click_x_q[b]      = '0;
      click_y_q[b]      = '0;
    end
    expected_beats.delete();
  endtask

  task automatic walk_buttons(input logic [TIME_W-1:0] now);
    mbpc_pkg::btn_state_e st;
    logic [TIME_W-1:0]    age;
    logic [TIME_W-1:0]    gap;
    longint               dx;
    longint               dy;
    longint               dist2;
    longint               rad2;
    mbpc_pkg::out_item_t  beat;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      st = press_q[b];
      if (!levels_q[b]) begin
        click_x_q[b] = '0;
        click_y_q[b] = '0;
        st = mbpc_pkg::BST_RELEASED;
      end else begin
        if (st == mbpc_pkg::BST_PRESSED) begin
          age = now - click_t_q[b];
          if (age >= hold_min_q) st = mbpc_pkg::BST_HELD;
          gap = click_t_q[b] - prev_click_t_q[b];
          if (gap < dc_window_q) begin
            dx    = longint'(ptr_x_q) - longint'(click_x_q[b]);
            dy    = longint'(ptr_y_q) - longint'(click_y_q[b]);
            dist2 = dx * dx + dy * dy;
            rad2  = longint'(dc_radius_q) * longint'(dc_radius_q);
            if (dist2 < rad2) st = mbpc_pkg::BST_REPEAT;
          end
        end
        if (st == mbpc_pkg::BST_HELD) hold_q[b] = now - click_t_q[b];
        if (st == mbpc_pkg::BST_RELEASED) begin
          click_x_q[b]      = ptr_x_q;
          click_y_q[b]      = ptr_y_q;
          prev_click_t_q[b] = click_t_q[b];
          click_t_q[b]      = now;
          st = mbpc_pkg::BST_PRESSED;
        end
      end
      press_q[b] = st;
      beat.button_number = SEL_W'(b);
      beat.button_state  = st;
      beat.hold_time     = hold_q[b];
      beat.last          = (b == NUM_BUTTONS - 1);
      expected_beats.push_back(beat);
    end
  endtask

  task automatic take_input();
    logic [SEL_W-1:0] sel;
    sel = s_axis_tdata[SEL_LSB +: SEL_W];
    case (s_axis_tuser)
      mbpc_pkg::CMD_MOVE: begin
        ptr_x_q = s_axis_tdata[X_LSB +: POS_W];
        ptr_y_q = s_axis_tdata[Y_LSB +: POS_W];
      end
      mbpc_pkg::CMD_LEVEL: begin
        if (sel < NUM_BUTTONS) levels_q[sel] = s_axis_tdata[DOWN_BIT];
      end
      mbpc_pkg::CMD_FRAME: begin
        if (s_axis_tdata[FOCUS_BIT]) walk_buttons(s_axis_tdata[TIME_W-1:0]);
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    mbpc_pkg::out_item_t want;
    logic [SEL_W-1:0]    got_num;
    logic [1:0]          got_st;
    logic [TIME_W-1:0]   got_hold;
    got_num  = m_axis_tdata[SEL_W-1:0];
    got_st   = m_axis_tdata[SEL_W +: 2];
    got_hold = m_axis_tdata[SEL_W + 2 +: TIME_W];
    if (expected_beats.size() == 0) begin
      if (fail_count_o < REPORT_MAX)
        $display("unexpected result beat: button %0d state %0d hold %0d last %0b",
                 got_num, got_st, got_hold, m_axis_tlast);
      fail_count_o++;
    end else begin
      want = expected_beats.pop_front();
      if (want.button_number !== got_num || want.button_state !== got_st ||
          want.hold_time !== got_hold || want.last !== m_axis_tlast) begin
        if (fail_count_o < REPORT_MAX)
          $display("result mismatch: exp button %0d state %0d hold %0d last %0b,",
                   want.button_number, want.button_state, want.hold_time, want.last,
                   " got button %0d state %0d hold %0d last %0b",
                   got_num, got_st, got_hold, m_axis_tlast);
        fail_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_model();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          mbpc_pkg::CFG_HOLD_MIN:  hold_min_q  = cfg_data_i;
          mbpc_pkg::CFG_DC_WINDOW: dc_window_q = cfg_data_i;
          mbpc_pkg::CFG_DC_RADIUS: dc_radius_q = cfg_data_i[RADIUS_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) take_input();
      if (m_axis_tvalid && m_axis_tready) check_result();
    end
    pending_o = expected_beats.size();
  end

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Bench for the mouse button press classifier. Runs a directed sequence over
// the press, hold, double-click and wrap cases, then random phases under
// several register settings and idle patterns, including a long result
// stall and a full drain. Checking is done by mbpc_checker.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CMD_W           = mbpc_pkg::CMD_W;
  localparam int unsigned TIME_W          = mbpc_pkg::TIME_W;
  localparam int unsigned POS_W           = mbpc_pkg::POS_W;
  localparam int unsigned SEL_W           = mbpc_pkg::SEL_W;
  localparam int unsigned CFG_IDX_W       = mbpc_pkg::CFG_IDX_W;
  localparam int unsigned IN_TDATA_W      = mbpc_pkg::IN_TDATA_W;
  localparam int unsigned OUT_TDATA_W     = mbpc_pkg::OUT_TDATA_W;
  localparam int unsigned NUM_BUTTONS     = 8;
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
  localparam int unsigned IDLE_LIMIT      = 2000;
  localparam int unsigned LONG_HOLD       = 300;
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned ITEMS_PER_PHASE = 77;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [TIME_W-1:0]      cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [CMD_W-1:0]       s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  int unsigned mismatch_count;
  int unsigned beats_outstanding;
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_reqs     = 0;
  int unsigned quiet_cycles  = 0;
  logic [TIME_W-1:0]  clock_ms = '0;
  logic [POS_W-1:0]   cur_x    = '0;
  logic [POS_W-1:0]   cur_y    = '0;

  mouse_button_press_classifier #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  mbpc_checker #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .fail_count_o (mismatch_count),
    .pending_o    (beats_outstanding)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (cfg_valid_i && cfg_ready_o) || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("[mouse_button_press_classifier] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result sink: random stalls, plus one long hold-off per request
  initial begin
    int unsigned holds_done;
    holds_done = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_reqs != holds_done) begin
        holds_done = holds_done + 1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  function automatic logic [IN_TDATA_W-1:0] pack_beat(input logic [TIME_W-1:0] now,
                                                       input logic foc,
                                                       input logic [POS_W-1:0] x,
                                                       input logic [POS_W-1:0] y,
                                                       input logic [SEL_W-1:0] sel,
                                                       input logic down);
    return {3'b000, down, sel, y, x, foc, now};
  endfunction

  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [IN_TDATA_W-1:0] data);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_frame(input logic [TIME_W-1:0] now, input logic foc);
    send_beat(mbpc_pkg::CMD_FRAME, pack_beat(now, foc, POS_W'($urandom), POS_W'($urandom),
                                             SEL_W'($urandom), 1'($urandom)));
  endtask

  task automatic send_move(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
    cur_x = x;
    cur_y = y;
    send_beat(mbpc_pkg::CMD_MOVE, pack_beat($urandom, 1'($urandom), x, y,
                                            SEL_W'($urandom), 1'($urandom)));
  endtask

  task automatic send_level(input logic [SEL_W-1:0] sel, input logic down);
    send_beat(mbpc_pkg::CMD_LEVEL, pack_beat($urandom, 1'($urandom), POS_W'($urandom),
                                             POS_W'($urandom), sel, down));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (beats_outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input mbpc_pkg::cfg_idx_e idx, input logic [TIME_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      if ($urandom_range(19) == 0) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(700);
      send_frame(clock_ms, $urandom_range(9) != 0);
    end else if (pick < 65) begin
      if ($urandom_range(9) < 7)
        send_move(cur_x + POS_W'($urandom_range(6)) - POS_W'(3),
                  cur_y + POS_W'($urandom_range(6)) - POS_W'(3));
      else
        send_move(POS_W'($urandom), POS_W'($urandom));
    end else if (pick < 95) begin
      send_level(SEL_W'($urandom_range(7)), 1'($urandom_range(1)));
    end else begin
      send_beat(CMD_RESERVED, pack_beat($urandom, 1'($urandom), POS_W'($urandom),
                                        POS_W'($urandom), SEL_W'($urandom), 1'($urandom)));
    end
  endtask

  task automatic run_phase(input logic [TIME_W-1:0] hold_min, input logic [TIME_W-1:0] window,
                           input logic [TIME_W-1:0] radius, input int unsigned src_pct,
                           input int unsigned snk_pct, input bit pressure);
    drain_results();
    write_reg(mbpc_pkg::CFG_HOLD_MIN, hold_min);
    write_reg(mbpc_pkg::CFG_DC_WINDOW, window);
    write_reg(mbpc_pkg::CFG_DC_RADIUS, radius);
    cfg_valid_i   <= 1'b0;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      if (pressure && i == 10) hold_reqs = hold_reqs + 1;
      if (pressure && i == 50) drain_results();
      random_item();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_frame(32'd0, 1'b1);
    send_beat(CMD_RESERVED, pack_beat('1, 1'b1, '1, '1, '1, 1'b1));
    send_move(16'h8000, 16'h7FFF);
    send_level(3'd0, 1'b1);
    send_level(3'd7, 1'b1);
    send_frame(32'd100, 1'b0);
    send_frame(32'd100, 1'b1);
    send_move(16'h7FFF, 16'h8000);
    send_frame(32'd700, 1'b1);
    send_level(3'd0, 1'b0);
    send_frame(32'd800, 1'b1);
    send_level(3'd0, 1'b1);
    send_frame(32'd900, 1'b1);
    send_level(3'd0, 1'b0);
    send_frame(32'd950, 1'b1);
    send_level(3'd0, 1'b1);
    send_frame(32'd1000, 1'b1);
    send_frame(32'd1010, 1'b1);
    send_move(16'h0000, 16'h0000);
    send_frame(32'hFFFF_FFFF, 1'b1);
    send_level(3'd7, 1'b0);
    send_level(3'd0, 1'b0);
    send_frame(32'hFFFF_FFFF, 1'b1);
    clock_ms = 32'd2000;

    run_phase(32'd0, 32'hFFFF_FFFF, 32'd32767, 78, 0, 1'b0);
    run_phase(32'hFFFF_FFFF, 32'd0, 32'd0, 0, 78, 1'b0);
    run_phase(32'd250, 32'd400, 32'd6, 26, 26, 1'b0);
    run_phase(32'd500, 32'd300, 32'd4, 0, 0, 1'b1);
    drain_results();

    if (mismatch_count == 0) begin
      $display("[mouse_button_press_classifier] OK");
    end else begin
      $display("[mouse_button_press_classifier] ERROR");
    end
    $finish;
  end

endmodule
